[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while reset is high
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Clocked next-cycle implication check
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/c6502_pkg.sv]
// Package: types, flag masks, decode codes and decode functions of the 6502 bus-cycle core
`default_nettype none
package c6502_pkg;
  typedef logic [7:0] byte_t;
  typedef logic [15:0] addr_t;

  localparam byte_t FLAG_C = 8'h01;
  localparam byte_t FLAG_Z = 8'h02;
  localparam byte_t FLAG_I = 8'h04;
  localparam byte_t FLAG_D = 8'h08;
  localparam byte_t FLAG_B = 8'h10;
  localparam byte_t FLAG_V = 8'h40;
  localparam byte_t FLAG_N = 8'h80;
  localparam byte_t P_RESET = 8'h34;
  localparam byte_t SP_RESET = 8'hFD;
  localparam byte_t STACK_HI = 8'h01;
  localparam addr_t RESET_VECTOR = 16'hFFFC;
  localparam addr_t NMI_VECTOR = 16'hFFFA;

  // addressing modes
  localparam logic [3:0] M_IMP = 4'd0, M_IMM = 4'd1, M_ZP = 4'd2, M_ZPX = 4'd3,
    M_ZPY = 4'd4, M_ABS = 4'd5, M_ABX = 4'd6, M_ABY = 4'd7, M_REL = 4'd8,
    M_XIN = 4'd9, M_INY = 4'd10, M_IND = 4'd11;

  // instruction kinds
  localparam logic [5:0] K_NOP = 6'd0, K_ORA = 6'd1, K_AND = 6'd2, K_EOR = 6'd3,
    K_ADC = 6'd4, K_STA = 6'd5, K_LDA = 6'd6, K_CMP = 6'd7, K_SBC = 6'd8,
    K_ASL = 6'd9, K_ROL = 6'd10, K_LSR = 6'd11, K_ROR = 6'd12, K_STX = 6'd13,
    K_LDX = 6'd14, K_DEC = 6'd15, K_INC = 6'd16, K_STY = 6'd17, K_LDY = 6'd18,
    K_CPY = 6'd19, K_CPX = 6'd20, K_BIT = 6'd21, K_JMP = 6'd22, K_JSR = 6'd23,
    K_RTS = 6'd24, K_RTI = 6'd25, K_BRK = 6'd26, K_BR = 6'd27, K_PHP = 6'd28,
    K_PLP = 6'd29, K_PHA = 6'd30, K_PLA = 6'd31, K_DEY = 6'd32, K_TAY = 6'd33,
    K_INY = 6'd34, K_INX = 6'd35, K_FLAG = 6'd36, K_TYA = 6'd37, K_TXA = 6'd38,
    K_TAX = 6'd39, K_DEX = 6'd40, K_TXS = 6'd41, K_TSX = 6'd42, K_AAC = 6'd43,
    K_ASR = 6'd44, K_ARR = 6'd45, K_AAX = 6'd46, K_KIL = 6'd47;

  // bus cycle steps
  localparam logic [3:0] S_VLO = 4'd0, S_VHI = 4'd1, S_OP = 4'd2, S_B1 = 4'd3,
    S_B2 = 4'd4, S_PLO = 4'd5, S_PHI = 4'd6, S_RD = 4'd7, S_WEND = 4'd8,
    S_N1 = 4'd9, S_N2 = 4'd10, S_N3 = 4'd11, S_JSR1 = 4'd12, S_POP1 = 4'd13,
    S_POP2 = 4'd14, S_POP3 = 4'd15;

  function automatic logic [3:0] mode_of(input byte_t op);
    logic [2:0] a, b;
    logic [1:0] c;
    logic [3:0] m;
    a = op[7:5];
    b = op[4:2];
    c = op[1:0];
    if (c[0]) begin
      case (b)
        3'd0: m = M_XIN;
        3'd1: m = M_ZP;
        3'd2: m = M_IMM;
        3'd3: m = M_ABS;
        3'd4: m = M_INY;
        3'd5: m = M_ZPX;
        3'd6: m = M_ABY;
        default: m = M_ABX;
      endcase
    end else begin
      case (b)
        3'd0: m = (a >= 3'd4) ? M_IMM : ((c == 2'd0 && a == 3'd1) ? M_ABS : M_IMP);
        3'd1: m = M_ZP;
        3'd3: m = (c == 2'd0 && a == 3'd3) ? M_IND : M_ABS;
        3'd4: m = (c == 2'd0) ? M_REL : M_IMP;
        3'd5: m = M_ZPX;
        3'd7: m = M_ABX;
        default: m = M_IMP;
      endcase
    end
    if (c[1] && (a == 3'd4 || a == 3'd5)) begin
      if (m == M_ZPX) m = M_ZPY;
      if (m == M_ABX) m = M_ABY;
    end
    return m;
  endfunction

  function automatic logic [5:0] kind_of(input byte_t op);
    logic [2:0] a, b;
    logic [1:0] c;
    logic [5:0] k;
    a = op[7:5];
    b = op[4:2];
    c = op[1:0];
    k = K_NOP;
    if (c == 2'd1) begin
      k = (op == 8'h89) ? K_NOP : K_ORA + {3'd0, a};
    end else if (c == 2'd3) begin
      if (b == 3'd2) begin
        if (a < 3'd2) k = K_AAC;
        else if (a == 3'd2) k = K_ASR;
        else if (a == 3'd3) k = K_ARR;
        else if (a == 3'd7) k = K_SBC;
      end else if (a == 3'd4 && (b == 3'd0 || b == 3'd1 || b == 3'd3 || b == 3'd5)) begin
        k = K_AAX;
      end
    end else if (c == 2'd2) begin
      if (b == 3'd4 || (b == 3'd0 && a < 3'd4)) k = K_KIL;
      else if (b == 3'd0) k = (a == 3'd5) ? K_LDX : K_NOP;
      else if (b == 3'd2 && a >= 3'd4)
        k = (a == 3'd4) ? K_TXA : (a == 3'd5) ? K_TAX : (a == 3'd6) ? K_DEX : K_NOP;
      else if (b == 3'd6) k = (a == 3'd4) ? K_TXS : (a == 3'd5) ? K_TSX : K_NOP;
      else if (b == 3'd7 && a == 3'd4) k = K_NOP;
      else k = K_ASL + {3'd0, a};
    end else begin
      if (b == 3'd4) k = K_BR;
      else if (b == 3'd2) begin
        case (a)
          3'd0: k = K_PHP;
          3'd1: k = K_PLP;
          3'd2: k = K_PHA;
          3'd3: k = K_PLA;
          3'd4: k = K_DEY;
          3'd5: k = K_TAY;
          3'd6: k = K_INY;
          default: k = K_INX;
        endcase
      end else if (b == 3'd6) k = (a == 3'd4) ? K_TYA : K_FLAG;
      else if (b == 3'd0 && a < 3'd4) begin
        case (a[1:0])
          2'd0: k = K_BRK;
          2'd1: k = K_JSR;
          2'd2: k = K_RTI;
          default: k = K_RTS;
        endcase
      end else if (a >= 3'd4) begin
        if ((b == 3'd0 && a == 3'd4) || (b == 3'd5 && a >= 3'd6) || (b == 3'd7 && a != 3'd5))
          k = K_NOP;
        else k = K_STY + {4'd0, a[1:0]};
      end else if (a == 3'd1 && (b == 3'd1 || b == 3'd3)) k = K_BIT;
      else if (b == 3'd3 && a >= 3'd2) k = K_JMP;
    end
    return k;
  endfunction

  function automatic logic is_read(input logic [5:0] k);
    return (k >= K_ORA && k <= K_SBC && k != K_STA) || k == K_LDX || k == K_LDY ||
           k == K_CPY || k == K_CPX || k == K_BIT;
  endfunction

  function automatic logic is_rmw(input logic [5:0] k);
    return (k >= K_ASL && k <= K_ROR) || k == K_DEC || k == K_INC;
  endfunction
endpackage
`default_nettype wire

[hdl/c6502_if.sv]
// Valid/ready channel interfaces for the core's input and result transactions
`default_nettype none
interface c6502_in_if;
  logic valid;
  logic ready;
  logic command;
  logic [7:0] read_data;
  logic nmi_request;
  modport source (output valid, command, read_data, nmi_request, input ready);
  modport sink (input valid, command, read_data, nmi_request, output ready);
endinterface

interface c6502_out_if;
  logic valid;
  logic ready;
  logic [15:0] bus_address;
  logic [7:0] bus_write_data;
  logic bus_write;
  logic instruction_end;
  logic undefined_opcode;
  modport source (output valid, bus_address, bus_write_data, bus_write, instruction_end,
                  undefined_opcode, input ready);
  modport sink (input valid, bus_address, bus_write_data, bus_write, instruction_end,
                undefined_opcode, output ready);
endinterface
`default_nettype wire

[hdl/cpu_6502_bus_cycle_core_unit.sv]
// Top level: 6502-style core that executes one bus cycle per input transaction
// The result is registered: it appears in the cycle after its input is accepted.
// Throughput: one transaction per cycle while out_ch.ready takes each result.
// The next-state logic of one bus cycle (decode, ALU, address add) sits between
// the architectural registers and the result register.
// Reset: rst clears the result valid; the core state starts as a vector read at 0.
`default_nettype none
module cpu_6502_bus_cycle_core_unit (
  input wire logic clk,
  input wire logic rst,
  c6502_in_if.sink in_ch,
  c6502_out_if.source out_ch
);
  import c6502_pkg::*;

  byte_t accumulator, index_x, index_y, status_flags, stack_low;
  addr_t program_counter, address_latch;
  byte_t opcode_latch, data_latch;
  logic [3:0] cycle_step;
  logic out_valid;
  addr_t out_addr;
  byte_t out_wdata;
  logic out_write, out_end, out_und;

  byte_t a_n, x_n, y_n, p_n, sp_n, op_n, dl_n;
  addr_t pc_n, al_n;
  logic [3:0] st_n;
  addr_t o_addr;
  byte_t o_wdata;
  logic o_write, o_end, o_und;

  logic take;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  // Next state of one bus cycle
  always_comb begin
    byte_t d, op, m8, v, r, t;
    logic [5:0] k;
    logic [3:0] md;
    logic [8:0] s;
    addr_t ea;
    logic do_exec, do_bound, samp, do_alu, do_impl, cin, taken;
    byte_t mm;
    d = in_ch.read_data;
    a_n = accumulator; x_n = index_x; y_n = index_y; p_n = status_flags;
    sp_n = stack_low; pc_n = program_counter; al_n = address_latch;
    op_n = opcode_latch; dl_n = data_latch; st_n = cycle_step;
    o_addr = 16'h0; o_wdata = 8'h0; o_write = 1'b0; o_end = 1'b0; o_und = 1'b0;
    op = opcode_latch;
    do_exec = 1'b0; do_bound = 1'b0; samp = 1'b1; do_alu = 1'b0; do_impl = 1'b0;
    ea = 16'h0; m8 = d; v = 8'h0; r = 8'h0; t = 8'h0; s = 9'h0; mm = 8'h0;
    cin = 1'b0; taken = 1'b0;
    if (cycle_step == S_OP) op = d;
    k = kind_of(op);
    md = mode_of(op);
    if (!in_ch.command) begin
      a_n = 8'h0; x_n = 8'h0; y_n = 8'h0; p_n = P_RESET; sp_n = SP_RESET;
      pc_n = 16'h0; op_n = 8'h0; dl_n = 8'h0;
      al_n = RESET_VECTOR; o_addr = RESET_VECTOR; st_n = S_VLO;
    end else begin
      case (cycle_step)
        S_VLO: begin
          dl_n = d; o_addr = address_latch + 16'd1; st_n = S_VHI;
        end
        S_VHI: begin
          pc_n = {d, data_latch}; do_bound = 1'b1; samp = (address_latch != NMI_VECTOR);
        end
        S_OP: begin
          op_n = d; o_und = (k == K_KIL);
          if (md == M_IMP) do_impl = 1'b1;
          else begin
            o_addr = program_counter; pc_n = program_counter + 16'd1; st_n = S_B1;
          end
        end
        S_B1: begin
          if (md == M_IMM) begin
            do_alu = 1'b1; do_bound = 1'b1;
          end else if (md == M_ZP) begin
            do_exec = 1'b1; ea = {8'h0, d};
          end else if (md == M_ZPX) begin
            do_exec = 1'b1; ea = {8'h0, d + index_x};
          end else if (md == M_ZPY) begin
            do_exec = 1'b1; ea = {8'h0, d + index_y};
          end else if (md == M_REL) begin
            case (op[7:6])
              2'd0: taken = status_flags[7];
              2'd1: taken = status_flags[6];
              2'd2: taken = status_flags[0];
              default: taken = status_flags[1];
            endcase
            if (taken == op[5]) pc_n = program_counter + {{8{d[7]}}, d};
            do_bound = 1'b1;
          end else if (md == M_XIN || md == M_INY) begin
            al_n = {8'h0, (md == M_XIN) ? d + index_x : d};
            o_addr = al_n; st_n = S_PLO;
          end else begin
            dl_n = d; o_addr = program_counter; pc_n = program_counter + 16'd1; st_n = S_B2;
          end
        end
        S_B2: begin
          ea = {d, data_latch};
          if (md == M_ABX) ea = ea + {8'h0, index_x};
          if (md == M_ABY) ea = ea + {8'h0, index_y};
          if (md == M_IND) begin
            al_n = ea; o_addr = ea; st_n = S_PLO;
          end else do_exec = 1'b1;
        end
        S_PLO: begin
          dl_n = d; o_addr = address_latch + 16'd1; st_n = S_PHI;
        end
        S_PHI: begin
          ea = {d, data_latch};
          if (md == M_INY) ea = ea + {8'h0, index_y};
          do_exec = 1'b1;
        end
        S_RD: begin
          if (is_rmw(k)) begin
            mm = d; o_addr = address_latch; o_write = 1'b1; st_n = S_WEND;
          end else begin
            do_alu = 1'b1; do_bound = 1'b1;
          end
        end
        S_JSR1: begin
          ea = program_counter - 16'd1;
          o_addr = {STACK_HI, stack_low}; o_write = 1'b1; o_wdata = ea[7:0];
          sp_n = stack_low - 8'd1; st_n = S_WEND; pc_n = address_latch;
        end
        S_N1: begin
          o_addr = {STACK_HI, stack_low}; o_write = 1'b1; o_wdata = program_counter[7:0];
          sp_n = stack_low - 8'd1; st_n = S_N2;
        end
        S_N2: begin
          o_addr = {STACK_HI, stack_low}; o_write = 1'b1; o_wdata = status_flags;
          sp_n = stack_low - 8'd1; st_n = S_N3; p_n = status_flags | FLAG_I;
        end
        S_N3: begin
          al_n = NMI_VECTOR; o_addr = NMI_VECTOR; st_n = S_VLO;
        end
        S_POP1: begin
          if (k == K_RTS || k == K_RTI) begin
            if (k == K_RTS) dl_n = d; else p_n = d;
            sp_n = stack_low + 8'd1; o_addr = {STACK_HI, sp_n}; st_n = S_POP2;
          end else begin
            if (k == K_PLA) a_n = d; else if (k == K_PLP) p_n = d;
            do_bound = 1'b1;
          end
        end
        S_POP2: begin
          if (k == K_RTI) begin
            dl_n = d; sp_n = stack_low + 8'd1; o_addr = {STACK_HI, sp_n}; st_n = S_POP3;
          end else begin
            if (k == K_RTS) pc_n = {d, data_latch} + 16'd1;
            do_bound = 1'b1;
          end
        end
        S_POP3: begin
          pc_n = {d, data_latch}; do_bound = 1'b1;
        end
        default: do_bound = 1'b1;
      endcase

      // ALU read
      if (do_alu) begin
        cin = status_flags[0];
        t = accumulator & m8;
        case (k)
          K_ORA: begin a_n = accumulator | m8; p_n[7] = a_n[7]; p_n[1] = (a_n == 8'h0); end
          K_AND: begin a_n = t; p_n[7] = t[7]; p_n[1] = (t == 8'h0); end
          K_EOR: begin a_n = accumulator ^ m8; p_n[7] = a_n[7]; p_n[1] = (a_n == 8'h0); end
          K_ADC, K_SBC: begin
            v = (k == K_SBC) ? ~m8 : m8;
            s = {1'b0, accumulator} + {1'b0, v} + {8'h0, cin};
            p_n[6] = ~(accumulator[7] ^ v[7]) & (accumulator[7] ^ s[7]);
            p_n[0] = s[8];
            a_n = s[7:0]; p_n[7] = a_n[7]; p_n[1] = (a_n == 8'h0);
          end
          K_LDA: begin a_n = m8; p_n[7] = m8[7]; p_n[1] = (m8 == 8'h0); end
          K_LDX: begin x_n = m8; p_n[7] = m8[7]; p_n[1] = (m8 == 8'h0); end
          K_LDY: begin y_n = m8; p_n[7] = m8[7]; p_n[1] = (m8 == 8'h0); end
          K_CMP, K_CPX, K_CPY: begin
            v = (k == K_CMP) ? accumulator : (k == K_CPX) ? index_x : index_y;
            r = v - m8;
            p_n[0] = (v >= m8); p_n[7] = r[7]; p_n[1] = (r == 8'h0);
          end
          K_BIT: begin p_n[6] = m8[6]; p_n[7] = m8[7]; p_n[1] = (t == 8'h0); end
          K_AAC: begin a_n = t; p_n[7] = t[7]; p_n[1] = (t == 8'h0); p_n[0] = t[7]; end
          K_ASR: begin
            p_n[0] = t[0]; a_n = {1'b0, t[7:1]}; p_n[7] = 1'b0; p_n[1] = (a_n == 8'h0);
          end
          K_ARR: begin
            a_n = {cin, t[7:1]}; p_n[0] = a_n[6]; p_n[6] = a_n[6] ^ a_n[5];
            p_n[7] = a_n[7]; p_n[1] = (a_n == 8'h0);
          end
          default: ;
        endcase
      end

      // Effective address use
      if (do_exec) begin
        al_n = ea;
        if (is_read(k) || is_rmw(k)) begin
          o_addr = ea; st_n = S_RD;
        end else if (k == K_STA || k == K_STX || k == K_STY || k == K_AAX) begin
          v = (k == K_STA) ? accumulator : (k == K_STX) ? index_x :
              (k == K_STY) ? index_y : (accumulator & index_x);
          if (k == K_AAX) begin p_n[7] = v[7]; p_n[1] = (v == 8'h0); end
          o_addr = ea; o_write = 1'b1; o_wdata = v; st_n = S_WEND;
        end else if (k == K_JSR) begin
          r = 8'h0;
          {v, r} = program_counter - 16'd1;
          o_addr = {STACK_HI, stack_low}; o_write = 1'b1; o_wdata = v;
          sp_n = stack_low - 8'd1; st_n = S_JSR1;
        end else begin
          if (k == K_JMP) pc_n = ea;
          do_bound = 1'b1;
        end
      end

      // Implied instructions
      if (do_impl) begin
        do_bound = 1'b1;
        case (k)
          K_BRK: p_n = status_flags | FLAG_B;
          K_ASL, K_ROL, K_LSR, K_ROR: mm = accumulator;
          K_PHP, K_PHA: begin
            o_addr = {STACK_HI, stack_low}; o_write = 1'b1;
            o_wdata = (k == K_PHP) ? status_flags : accumulator;
            sp_n = stack_low - 8'd1; st_n = S_WEND; do_bound = 1'b0;
          end
          K_PLP, K_PLA, K_RTS, K_RTI: begin
            sp_n = stack_low + 8'd1; o_addr = {STACK_HI, sp_n}; st_n = S_POP1;
            do_bound = 1'b0;
          end
          K_DEY: y_n = index_y - 8'd1;
          K_INY: y_n = index_y + 8'd1;
          K_DEX: x_n = index_x - 8'd1;
          K_INX: x_n = index_x + 8'd1;
          K_TAY: y_n = accumulator;
          K_TAX: x_n = accumulator;
          K_TYA: a_n = index_y;
          K_TXA: a_n = index_x;
          K_TSX: x_n = stack_low;
          K_TXS: sp_n = index_x;
          K_FLAG: begin
            if (op == 8'h18 || op == 8'h38) p_n[0] = (op == 8'h38);
            else if (op == 8'h58 || op == 8'h78) p_n[2] = (op == 8'h78);
            else if (op == 8'hB8) p_n[6] = 1'b0;
            else p_n[3] = (op == 8'hF8);
          end
          default: ;
        endcase
        case (k)
          K_DEY, K_INY, K_TAY: begin p_n[7] = y_n[7]; p_n[1] = (y_n == 8'h0); end
          K_DEX, K_INX, K_TAX, K_TSX: begin p_n[7] = x_n[7]; p_n[1] = (x_n == 8'h0); end
          K_TYA, K_TXA: begin p_n[7] = a_n[7]; p_n[1] = (a_n == 8'h0); end
          default: ;
        endcase
      end

      // Shift, rotate, increment and decrement
      if ((do_impl && k >= K_ASL && k <= K_ROR) || (cycle_step == S_RD && is_rmw(k))) begin
        cin = status_flags[0];
        case (k)
          K_ASL: begin r = {mm[6:0], 1'b0}; p_n[0] = mm[7]; end
          K_ROL: begin r = {mm[6:0], cin}; p_n[0] = mm[7]; end
          K_LSR: begin r = {1'b0, mm[7:1]}; p_n[0] = mm[0]; end
          K_ROR: begin r = {cin, mm[7:1]}; p_n[0] = mm[0]; end
          K_DEC: r = mm - 8'd1;
          default: r = mm + 8'd1;
        endcase
        p_n[7] = r[7]; p_n[1] = (r == 8'h0);
        if (do_impl) a_n = r; else o_wdata = r;
      end

      // Instruction boundary: NMI entry or opcode fetch
      if (do_bound) begin
        if (samp && in_ch.nmi_request) begin
          p_n[4] = 1'b0;
          o_addr = {STACK_HI, stack_low}; o_write = 1'b1; o_wdata = pc_n[15:8];
          sp_n = stack_low - 8'd1; st_n = S_N1;
        end else begin
          o_addr = pc_n; pc_n = pc_n + 16'd1; st_n = S_OP; o_end = 1'b1;
        end
      end
    end
  end

  // Advance architectural state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 8'h0; index_x <= 8'h0; index_y <= 8'h0;
      status_flags <= P_RESET; stack_low <= SP_RESET; program_counter <= 16'h0;
      opcode_latch <= 8'h0; cycle_step <= S_VLO; address_latch <= 16'h0;
      data_latch <= 8'h0; out_valid <= 1'b0;
    end else begin
      if (take) begin
        accumulator <= a_n; index_x <= x_n; index_y <= y_n; status_flags <= p_n;
        stack_low <= sp_n; program_counter <= pc_n; opcode_latch <= op_n;
        cycle_step <= st_n; address_latch <= al_n; data_latch <= dl_n;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (take) begin
      out_addr <= o_addr; out_wdata <= o_wdata; out_write <= o_write;
      out_end <= o_end; out_und <= o_und;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.bus_address = out_addr;
  assign out_ch.bus_write_data = out_wdata;
  assign out_ch.bus_write = out_write;
  assign out_ch.instruction_end = out_end;
  assign out_ch.undefined_opcode = out_und;
endmodule
`default_nettype wire

[hdl/c6502_checker.sv]
// Port-level checker for the 6502 bus-cycle core, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module c6502_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_command,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_write,
  input wire logic [7:0] out_wdata,
  input wire logic out_end
);
  `CHK_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid, "no result after transaction")
  `CHK_IMPL(a_ready_free, clk, rst, !out_valid, in_ready, "input stalled with empty output")
  `CHK_NEXT(a_reset_read, clk, rst, in_valid && in_ready && !in_command, !out_write && !out_end, "reset command must issue vector read")
  `CHK_IMPL(a_read_zero, clk, rst, out_valid && !out_write, out_wdata == 8'h00, "read carries write data")
  `CHK_IMPL(a_fetch_read, clk, rst, out_valid && out_end, !out_write, "opcode fetch must be a read")
endmodule

bind cpu_6502_bus_cycle_core_unit c6502_checker u_c6502_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_command(in_ch.command), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_write(out_ch.bus_write), .out_wdata(out_ch.bus_write_data),
  .out_end(out_ch.instruction_end)
);
`default_nettype wire
